// ===== rtl/sgnm_pkg.sv =====
// shared types and constants of the sorted grid nearest match unit
`default_nettype none

package sgnm_pkg;

	localparam int DATA_W = 32;
	localparam int IDX_W  = 10;

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef struct packed {
		logic                     command;
		logic signed [DATA_W-1:0] value;
		logic                     first;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]  nearest_index;
		logic [DATA_W-1:0] distance;
		logic              empty_error;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_BEST = 4'b0010,
		ST_STEP = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/sgnm_stream_if.sv =====
// valid/ready stream channel carrying one payload per beat
`default_nettype none

interface sgnm_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/sorted_grid_nearest_match_unit.sv =====
// flow: a load beat writes the grid and leaves the unit idle; a query passes through the best
// and step states to done, which waits for a free output slot (idle straight to done on an empty
// grid), with at most one forward pointer step per step state; one item at a time, set by the single
// grid memory read port feeding one shared subtract and compare unit
// reset: arst_n clears the point count, the pointer, the state and the output valid;
// grid memory contents are not cleared and need no clearing pass
`default_nettype none

module sorted_grid_nearest_match_unit #(
	parameter int MAX_POINTS = 1024
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	sgnm_stream_if.sink   req,
	sgnm_stream_if.source rsp
);
	import sgnm_pkg::*;

	localparam int IW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW  = $clog2(MAX_POINTS + 1);
	localparam int CW1 = CW + 1;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_POINTS);

	state_t st_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] ptr_q;
	logic signed [DATA_W-1:0] val_q;
	logic [DATA_W-1:0] best_q;
	logic err_q;
	logic out_valid_q;
	out_item_t out_q;

	logic [DATA_W-1:0] base_mem_q [MAX_POINTS];
	logic [DATA_W-1:0] rdata_q;
	logic [IW-1:0] rd_addr;

	logic acc, is_query, mem_we, slot_free;
	logic [CW-1:0] load_count;
	logic [IW-1:0] qptr, qptr_c;
	logic [CW1-1:0] ptr_x, cnt_x;
	logic has_next, has_next2, closer;
	logic [DATA_W:0] diff;
	logic [DATA_W-1:0] gap;

	assign req.ready = (st_q == ST_IDLE);
	assign acc       = req.valid && req.ready;
	assign is_query  = (req.payload.command == CMD_QUERY);

	// load path: first restarts the grid at entry zero
	assign load_count = req.payload.first ? '0 : count_q;
	assign mem_we     = acc && !is_query && (load_count < MAX_C);

	// query start pointer, clamped into the stored range
	assign qptr   = req.payload.first ? '0 : ptr_q;
	assign qptr_c = (CW1'(qptr) >= CW1'(count_q)) ? IW'(count_q - CW'(1)) : qptr;

	assign ptr_x     = CW1'(ptr_q);
	assign cnt_x     = CW1'(count_q);
	assign has_next  = (ptr_x + CW1'(1)) < cnt_x;
	assign has_next2 = (ptr_x + CW1'(2)) < cnt_x;

	always_comb begin
		unique case (st_q)
			ST_IDLE: rd_addr = qptr_c;
			ST_STEP: rd_addr = ptr_q + IW'(2);
			default: rd_addr = ptr_q + IW'(1);
		endcase
	end

	// shared absolute difference unit against the word just read
	assign diff   = {val_q[DATA_W-1], val_q} - {rdata_q[DATA_W-1], rdata_q};
	assign gap    = diff[DATA_W] ? DATA_W'(-diff) : diff[DATA_W-1:0];
	assign closer = best_q > gap;

	assign slot_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			base_mem_q[load_count[IW-1:0]] <= req.payload.value;
		end
		rdata_q <= base_mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			count_q     <= '0;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (acc && !is_query) begin
						if (req.payload.first) begin
							ptr_q <= '0;
						end
						if (mem_we) begin
							count_q <= load_count + CW'(1);
						end
					end else if (acc) begin
						if (count_q == '0) begin
							ptr_q <= qptr;
							st_q  <= ST_DONE;
						end else begin
							ptr_q <= qptr_c;
							st_q  <= ST_BEST;
						end
					end
				end
				ST_BEST: begin
					st_q <= has_next ? ST_STEP : ST_DONE;
				end
				ST_STEP: begin
					if (closer) begin
						ptr_q <= ptr_q + IW'(1);
						st_q  <= has_next2 ? ST_STEP : ST_DONE;
					end else begin
						st_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase

			if (st_q == ST_DONE && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && is_query) begin
			val_q  <= req.payload.value;
			err_q  <= (count_q == '0);
			best_q <= '0;
		end
		if (st_q == ST_BEST || (st_q == ST_STEP && closer)) begin
			best_q <= gap;
		end
		if (st_q == ST_DONE && slot_free) begin
			out_q.nearest_index <= err_q ? '0 : IDX_W'(ptr_q);
			out_q.distance      <= err_q ? '0 : best_q;
			out_q.empty_error   <= err_q;
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_C)
		else $error("point count beyond depth");

	a_ptr_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_DONE && count_q != '0) |-> (CW1'(ptr_q) < CW1'(count_q)))
		else $error("pointer outside stored grid");

	a_step_has_next: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_STEP) |-> has_next)
		else $error("compare step without a next point");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.empty_error) |->
			(out_q.distance == '0 && out_q.nearest_index == '0))
		else $error("empty grid result not zeroed");
`endif

endmodule

`default_nettype wire
